// ===== hw/rtl/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg: shared definitions for the deadline timer table
// Field widths, request kind codes, datapath operation codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int KIND_W        = 3;
   localparam int HANDLE_W      = 4;
   localparam int SLOT_W        = 4;
   localparam int TIME_W        = 64;
   localparam int IVL_W         = 32;
   // handle/slot widening width; covers slot indexes for up to 127 slots
   localparam int EXT_W         = 7;

   localparam logic [IVL_W-1:0]  ROLLOVER_RESET = IVL_W'(60 * 60 * 1000);
   localparam logic [TIME_W-1:0] WAIT_EMPTY     = {TIME_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REFRESH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RESET   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EXPIRE  = 3'd5;

   localparam logic [2:0] OP_NOP   = 3'd0;
   localparam logic [2:0] OP_SCAN  = 3'd1;
   localparam logic [2:0] OP_CALC  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_ROLL  = 3'd4;
   localparam logic [2:0] OP_PEND  = 3'd5;
   localparam logic [2:0] OP_EMIT  = 3'd6;

   typedef struct packed {
      logic       ready;
      logic [2:0] op;
   } dtt_cmd_type;

   typedef struct packed {
      logic              accepted;
      logic [KIND_W-1:0] kind;
      logic              scan_done;
      logic              ok;
      logic              free_valid;
      logic              fire;
      logic              due_any;
      logic              more;
      logic              any_active;
      logic              out_free;
   } dtt_stat_type;

endpackage

// ===== hw/rtl/dtt_if.sv =====
// ----------------------------------------------------------------------------
// dtt_if: request and response channels of the deadline timer table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface dtt_req_if;
   import dtt_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [TIME_W-1:0]   now_ms;
   logic [IVL_W-1:0]    interval_ms;
   logic                recurring;
   logic                restart_now;
   logic [HANDLE_W-1:0] handle;

   modport source(output valid, kind, now_ms, interval_ms, recurring, restart_now, handle,
                  input ready);
   modport sink(input valid, kind, now_ms, interval_ms, recurring, restart_now, handle,
                output ready);
endinterface

interface dtt_rsp_if;
   import dtt_pkg::*;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [SLOT_W-1:0] slot;
   logic [TIME_W-1:0] wait_ms;
   logic              front_signal;
   logic              fired;
   logic              pending;
   logic              last;

   modport source(output valid, ok, slot, wait_ms, front_signal, fired, pending, last,
                  input ready);
   modport sink(input valid, ok, slot, wait_ms, front_signal, fired, pending, last,
                output ready);
endinterface

// ===== hw/rtl/dtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtt_ctrl: sequencer of the deadline timer table
// Steps each request through the phases its kind needs: scan, read, calc, write, roll, pending check and emit.
// ----------------------------------------------------------------------------
module dtt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  dtt_pkg::dtt_stat_type stat,
   output dtt_pkg::dtt_cmd_type  cmd
);
   import dtt_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISP      = 4'd1;
   localparam logic [3:0] S_SCAN_GO   = 4'd2;
   localparam logic [3:0] S_SCAN_WAIT = 4'd3;
   localparam logic [3:0] S_SCAN_END  = 4'd4;
   localparam logic [3:0] S_READ      = 4'd5;
   localparam logic [3:0] S_CALC      = 4'd6;
   localparam logic [3:0] S_WRITE     = 4'd7;
   localparam logic [3:0] S_ROLL      = 4'd8;
   localparam logic [3:0] S_EXCHK     = 4'd9;
   localparam logic [3:0] S_EMIT      = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.ready = 1'b0;
      cmd.op    = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.accepted) state_in = S_DISP;
         end
         S_DISP: begin
            case (stat.kind)
               KIND_ADD, KIND_NEXT:     state_in = S_SCAN_GO;
               KIND_REFRESH, KIND_RESET: state_in = S_READ;
               KIND_EXPIRE:             state_in = stat.any_active ? S_ROLL : S_EMIT;
               default:                 state_in = S_EMIT;
            endcase
         end
         S_SCAN_GO: begin
            cmd.op   = OP_SCAN;
            state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (stat.scan_done) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            case (stat.kind)
               KIND_ADD: begin
                  if (!stat.ok && stat.free_valid) state_in = S_WRITE;
                  else                             state_in = S_EMIT;
               end
               KIND_EXPIRE: state_in = stat.fire ? S_READ : S_EXCHK;
               default:     state_in = S_EMIT;
            endcase
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.op   = OP_CALC;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op = OP_WRITE;
            if (stat.kind inside {KIND_ADD, KIND_RESET}) state_in = S_SCAN_GO;
            else                                         state_in = S_EMIT;
         end
         S_ROLL: begin
            cmd.op   = OP_ROLL;
            state_in = S_SCAN_GO;
         end
         S_EXCHK: begin
            cmd.op   = OP_PEND;
            state_in = stat.due_any ? S_READ : S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op = OP_EMIT;
               if (stat.kind == KIND_EXPIRE && stat.fire && stat.more) state_in = S_SCAN_GO;
               else                                                    state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/dtt_dp.sv =====
// ----------------------------------------------------------------------------
// dtt_dp: datapath of the deadline timer table
// Timer memories, slot flags, a sequential min-deadline scan unit and the
// response register.
// ----------------------------------------------------------------------------
module dtt_dp #(
   parameter int TIMER_SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtt_pkg::dtt_cmd_type    cmd,
   output dtt_pkg::dtt_stat_type   stat,
   dtt_req_if.sink                 req_ch,
   dtt_rsp_if.source               rsp_ch,
   input  logic                    csr_wr_en,
   input  logic [dtt_pkg::IVL_W-1:0] csr_wr_data
);
   import dtt_pkg::*;

   localparam int N  = TIMER_SLOTS;
   localparam int SW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(N + 1);

   logic [TIME_W-1:0] dl_mem [N];
   logic [IVL_W-1:0]  iv_mem [N];

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IVL_W-1:0]  ivl_ff, ivl_in;
   logic              rec_req_ff, rec_req_in;
   logic              restart_now_ff, restart_now_in;
   logic              hv_ff, hv_in;
   logic [SW-1:0]     tgt_ff, tgt_in;

   logic [N-1:0]      active_ff, active_in;
   logic [N-1:0]      rec_ff, rec_in;
   logic [N-1:0]      due_ff, due_in;
   logic              front_sig_ff, front_sig_in;
   logic [TIME_W-1:0] prev_ff, prev_in;
   logic [IVL_W-1:0]  window_ff, window_in;

   logic              scan_busy_ff, scan_busy_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic [SW-1:0]     rd_idx_ff, rd_idx_in;
   logic [TIME_W-1:0] dl_rd_ff;
   logic [IVL_W-1:0]  iv_rd_ff;
   logic              best_valid_ff, best_valid_in;
   logic [SW-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic              free_valid_ff, free_valid_in;
   logic [SW-1:0]     free_idx_ff, free_idx_in;

   logic              ok_ff, ok_in;
   logic              frontable_ff, frontable_in;
   logic              fire_ff, fire_in;
   logic              pend_ff, pend_in;
   logic              first_ff, first_in;
   logic              roll_ff, roll_in;
   logic [TIME_W-1:0] sum_ff, sum_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TIME_W-1:0] rsp_wait_ff, rsp_wait_in;
   logic              rsp_front_ff, rsp_front_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic              rsp_pend_ff, rsp_pend_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [SW-1:0]     rd_addr;
   logic              mem_we_dl, mem_we_iv;
   logic [SW-1:0]     wr_addr;
   logic [TIME_W-1:0] wr_dl;
   logic [IVL_W-1:0]  wr_iv;

   logic [EXT_W-1:0]  h_ext, tgt_ext, best_ext;
   logic [N-1:0]      m_bit;
   logic              cand, keep, upd, accept, is_exp, out_free;

   assign accept   = req_ch.valid && cmd.ready;
   assign is_exp   = (kind_ff == KIND_EXPIRE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign h_ext    = EXT_W'(req_ch.handle);
   assign tgt_ext  = EXT_W'(tgt_ff);
   assign best_ext = EXT_W'(best_idx_ff);
   assign m_bit    = N'(1) << best_idx_ff;
   assign rd_addr  = scan_busy_ff ? idx_ff[SW-1:0] : (is_exp ? best_idx_ff : tgt_ff);

   always_comb begin
      // scan candidate depends on the request being served
      if (is_exp && first_ff)
         cand = active_ff[rd_idx_ff] && (roll_ff || dl_rd_ff <= now_ff);
      else if (is_exp)
         cand = due_ff[rd_idx_ff];
      else
         cand = active_ff[rd_idx_ff];
   end

   always_comb begin
      kind_in        = kind_ff;
      now_in         = now_ff;
      ivl_in         = ivl_ff;
      rec_req_in     = rec_req_ff;
      restart_now_in = restart_now_ff;
      hv_in          = hv_ff;
      tgt_in         = tgt_ff;
      active_in      = active_ff;
      rec_in         = rec_ff;
      due_in         = due_ff;
      front_sig_in   = front_sig_ff;
      prev_in        = prev_ff;
      window_in      = window_ff;
      scan_busy_in   = scan_busy_ff;
      idx_in         = idx_ff;
      best_valid_in  = best_valid_ff;
      best_idx_in    = best_idx_ff;
      best_dl_in     = best_dl_ff;
      free_valid_in  = free_valid_ff;
      free_idx_in    = free_idx_ff;
      ok_in          = ok_ff;
      frontable_in   = frontable_ff;
      fire_in        = fire_ff;
      pend_in        = pend_ff;
      first_in       = first_ff;
      roll_in        = roll_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_pend_in    = rsp_pend_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we_dl      = 1'b0;
      mem_we_iv      = 1'b0;
      wr_addr        = tgt_ff;
      wr_dl          = sum_ff;
      wr_iv          = ivl_ff;
      keep           = 1'b0;
      upd            = 1'b0;

      // scan address sequencer
      rd_valid_in = scan_busy_ff;
      rd_idx_in   = idx_ff[SW-1:0];
      rd_last_in  = scan_busy_ff && (idx_ff == CW'(N - 1));
      if (scan_busy_ff) begin
         idx_in = idx_ff + CW'(1);
         if (idx_ff == CW'(N - 1)) scan_busy_in = 1'b0;
      end

      // scan compare: ascending index, strict less keeps the lower slot on ties
      if (rd_valid_ff) begin
         if (cand && (!best_valid_ff || dl_rd_ff < best_dl_ff)) begin
            best_valid_in = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_dl_in    = dl_rd_ff;
         end
         if (!active_ff[rd_idx_ff] && !free_valid_ff) begin
            free_valid_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         if (is_exp && first_ff && cand) due_in[rd_idx_ff] = 1'b1;
         if (rd_last_ff && is_exp) first_in = 1'b0;
      end

      case (cmd.op)
         OP_SCAN: begin
            scan_busy_in  = 1'b1;
            idx_in        = '0;
            best_valid_in = 1'b0;
            free_valid_in = 1'b0;
            if (is_exp && first_ff) due_in = '0;
         end
         OP_CALC: begin
            case (kind_ff)
               KIND_REFRESH: begin
                  ok_in  = hv_ff && active_ff[tgt_ff];
                  sum_in = now_ff + TIME_W'(iv_rd_ff);
               end
               KIND_RESET: begin
                  keep         = hv_ff && (ivl_ff == iv_rd_ff) && !restart_now_ff;
                  upd          = !keep && hv_ff && active_ff[tgt_ff];
                  ok_in        = keep || upd;
                  frontable_in = upd;
                  sum_in       = restart_now_ff ? now_ff : dl_rd_ff - TIME_W'(iv_rd_ff);
               end
               default: begin
                  sum_in = now_ff + TIME_W'(iv_rd_ff);
               end
            endcase
         end
         OP_WRITE: begin
            case (kind_ff)
               KIND_ADD: begin
                  mem_we_dl              = 1'b1;
                  mem_we_iv              = 1'b1;
                  wr_addr                = free_idx_ff;
                  wr_dl                  = now_ff + TIME_W'(ivl_ff);
                  rec_in[free_idx_ff]    = rec_req_ff;
                  active_in[free_idx_ff] = 1'b1;
                  tgt_in                 = free_idx_ff;
                  ok_in                  = 1'b1;
                  frontable_in           = 1'b1;
               end
               KIND_REFRESH: begin
                  mem_we_dl = ok_ff;
               end
               KIND_RESET: begin
                  mem_we_dl = frontable_ff;
                  mem_we_iv = frontable_ff;
                  wr_dl     = sum_ff + TIME_W'(ivl_ff);
               end
               KIND_EXPIRE: begin
                  // recurring timers rearm at now plus interval
                  mem_we_dl = rec_ff[best_idx_ff];
                  wr_addr   = best_idx_ff;
               end
               default: ;
            endcase
         end
         OP_ROLL: begin
            roll_in  = (now_ff < prev_ff) && ((prev_ff - now_ff) > TIME_W'(window_ff));
            prev_in  = now_ff;
            first_in = 1'b1;
         end
         OP_PEND: begin
            fire_in = |due_ff;
            pend_in = |(active_ff & ~(due_ff & ~rec_ff));
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = ok_ff;
            rsp_slot_in  = '0;
            rsp_wait_in  = '0;
            rsp_front_in = 1'b0;
            rsp_fired_in = 1'b0;
            rsp_last_in  = 1'b1;
            case (kind_ff)
               KIND_ADD: begin
                  rsp_slot_in = ok_ff ? tgt_ext[SLOT_W-1:0] : '0;
               end
               KIND_CANCEL: begin
                  rsp_ok_in = hv_ff && active_ff[tgt_ff];
                  if (hv_ff) active_in[tgt_ff] = 1'b0;
               end
               KIND_NEXT: begin
                  rsp_ok_in    = 1'b1;
                  front_sig_in = 1'b0;
                  if (!best_valid_ff)          rsp_wait_in = WAIT_EMPTY;
                  else if (now_ff >= best_dl_ff) rsp_wait_in = '0;
                  else                         rsp_wait_in = best_dl_ff - now_ff;
               end
               KIND_EXPIRE: begin
                  rsp_ok_in = 1'b1;
                  if (fire_ff) begin
                     rsp_fired_in = 1'b1;
                     rsp_slot_in  = best_ext[SLOT_W-1:0];
                     rsp_last_in  = ~|(due_ff & ~m_bit);
                     due_in       = due_ff & ~m_bit;
                     if (!rec_ff[best_idx_ff]) active_in[best_idx_ff] = 1'b0;
                  end
               end
               KIND_REFRESH, KIND_RESET: ;
               default: rsp_ok_in = 1'b0;
            endcase
            // front signal for a freshly placed deadline that is now earliest
            if ((kind_ff inside {KIND_ADD, KIND_RESET}) && frontable_ff &&
                best_valid_ff && best_idx_ff == tgt_ff && !front_sig_ff) begin
               rsp_front_in = 1'b1;
               front_sig_in = 1'b1;
            end
            rsp_pend_in = (is_exp && fire_ff) ? pend_ff : |active_in;
         end
         default: ;
      endcase

      if (accept) begin
         kind_in        = req_ch.kind;
         now_in         = req_ch.now_ms;
         ivl_in         = req_ch.interval_ms;
         rec_req_in     = req_ch.recurring;
         restart_now_in = req_ch.restart_now;
         hv_in          = h_ext < EXT_W'(N);
         tgt_in         = h_ext[SW-1:0];
         ok_in          = 1'b0;
         frontable_in   = 1'b0;
         fire_in        = 1'b0;
      end

      if (csr_wr_en) window_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we_dl) dl_mem[wr_addr] <= wr_dl;
      if (mem_we_iv) iv_mem[wr_addr] <= wr_iv;
      dl_rd_ff <= dl_mem[rd_addr];
      iv_rd_ff <= iv_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         front_sig_ff  <= 1'b0;
         prev_ff       <= '0;
         window_ff     <= ROLLOVER_RESET;
         scan_busy_ff  <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ok_ff         <= 1'b0;
         frontable_ff  <= 1'b0;
         fire_ff       <= 1'b0;
         first_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
         free_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         front_sig_ff  <= front_sig_in;
         prev_ff       <= prev_in;
         window_ff     <= window_in;
         scan_busy_ff  <= scan_busy_in;
         rd_valid_ff   <= rd_valid_in;
         rd_last_ff    <= rd_last_in;
         rsp_valid_ff  <= rsp_valid_in;
         ok_ff         <= ok_in;
         frontable_ff  <= frontable_in;
         fire_ff       <= fire_in;
         first_ff      <= first_in;
         best_valid_ff <= best_valid_in;
         free_valid_ff <= free_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      now_ff         <= now_in;
      ivl_ff         <= ivl_in;
      rec_req_ff     <= rec_req_in;
      restart_now_ff <= restart_now_in;
      hv_ff          <= hv_in;
      tgt_ff         <= tgt_in;
      rec_ff         <= rec_in;
      due_ff         <= due_in;
      idx_ff         <= idx_in;
      rd_idx_ff      <= rd_idx_in;
      best_idx_ff    <= best_idx_in;
      best_dl_ff     <= best_dl_in;
      free_idx_ff    <= free_idx_in;
      pend_ff        <= pend_in;
      roll_ff        <= roll_in;
      sum_ff         <= sum_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_pend_ff    <= rsp_pend_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ch.ready        = cmd.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.wait_ms      = rsp_wait_ff;
   assign rsp_ch.front_signal = rsp_front_ff;
   assign rsp_ch.fired        = rsp_fired_ff;
   assign rsp_ch.pending      = rsp_pend_ff;
   assign rsp_ch.last         = rsp_last_ff;

   assign stat.accepted   = accept;
   assign stat.kind       = kind_ff;
   assign stat.scan_done  = rd_valid_ff && rd_last_ff;
   assign stat.ok         = ok_ff;
   assign stat.free_valid = free_valid_ff;
   assign stat.fire       = fire_ff;
   assign stat.due_any    = |due_ff;
   assign stat.more       = |(due_ff & ~m_bit);
   assign stat.any_active = |active_ff;
   assign stat.out_free   = out_free;

endmodule

// ===== hw/rtl/deadline_timer_table.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_table: table of millisecond timers with earliest-deadline
// tracking and ordered expiry.
//
// Requests enter on req_ch (valid/ready) with a kind, the current time and
// the operands; responses leave on rsp_ch, one per request, or one per
// fired timer on expire with last set on the final one. csr_wr_en writes
// the rollover window. One request is in flight at a time; ready is high
// only while the sequencer is idle.
// The slot scan unit reads one deadline memory entry per cycle. Add and
// reset scan the table again after their write; expire scans again for
// each further fired timer.
// A response register sits at the output: a stalled receiver holds it and
// the sequencer waits before the next response.
// Reset clears all active marks, the front signal, the previous time and
// loads the default window; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deadline_timer_table #(
   parameter int TIMER_SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   dtt_req_if.sink                   req_ch,
   dtt_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [dtt_pkg::IVL_W-1:0] csr_wr_data
);
   import dtt_pkg::*;

   dtt_cmd_type  cmd;
   dtt_stat_type stat;

   dtt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   dtt_dp #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule
